>>> sv/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
`timescale 1ns / 1ps
`default_nettype none
package fpba_pkg;

	localparam int AMT_W      = 16;
	localparam int BLK_W      = 3;
	localparam int ACTIVE_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int FIELDS_W   = BLK_W + AMT_W;
	localparam int DATA_W     = ((FIELDS_W + 7) / 8) * 8;
	localparam int PAD_W      = DATA_W - FIELDS_W;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BLOCKS = 2'd1;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic valid;
		logic found;
	} tok_flags_t;

endpackage
`default_nettype wire

>>> sv/fit_policy_block_allocator.sv
// Top level of the fit-policy block allocator: cell chain, sequencer and stream ports.
//
// Usage:
// The input stream carries one word per operation. s_tuser is the opcode (load or
// allocate); s_tdata holds the block index and the amount. A load writes one
// block's free space and answers in the next cycle. An allocate sends a search
// word down a chain of NUM_BLOCKS cells, one cell per cycle; each cell compares
// its own free space with the request and keeps the better candidate under the
// current policy. The chosen block is written back as the result is registered,
// after the search word leaves the last cell and the sequencer passes through its
// finish state; the next word is taken once the sequencer is idle again and the
// result word can be replaced.
// The output stream carries one result word per operation: m_tuser is the grant
// flag and m_tdata holds the block number and the space left.
// The configuration channel writes the fit policy (index 0) and the active block
// count (index 1); it is always ready and should be used while the block is idle.
// Reset clears every block's free space to zero, sets first fit and eight active
// blocks. A stalled receiver holds the result word in the output register; the
// block takes a new word in the idle state as soon as that word can be replaced.
`timescale 1ns / 1ps
`default_nettype none
module fit_policy_block_allocator #(
	parameter int NUM_BLOCKS = 8,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [fpba_pkg::DATA_W-1:0]     s_tdata,   // block_index, amount, zero pad
	input  wire logic                            s_tuser,   // opcode
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [fpba_pkg::DATA_W-1:0]          m_tdata,   // block_number, space_left, zero pad
	output logic                                 m_tuser,   // granted
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	fpba_pkg::state_t state_q, state_nx;

	logic [1:0]                    policy_q;
	logic [fpba_pkg::ACTIVE_W-1:0] active_q;
	logic [SIZE_BITS-1:0]          amt_q;
	logic                          fin_found_q;
	logic [IDX_W-1:0]              fin_pick_q;
	logic [SIZE_BITS-1:0]          fin_best_q;
	logic                          out_valid_q;
	logic                          out_granted_q;
	logic [fpba_pkg::BLK_W-1:0]    out_block_q;
	logic [fpba_pkg::AMT_W-1:0]    out_space_q;

	logic                          s_accept;
	logic                          out_free;
	logic [fpba_pkg::BLK_W-1:0]    ld_idx;
	logic [31:0]                   ld_amt_ext;
	logic [SIZE_BITS-1:0]          ld_amt;
	logic                          ld_ok;
	logic [31:0]                   ld_idx_ext;
	logic [SIZE_BITS-1:0]          amt_cur;

	logic                          wr_en;
	logic [IDX_W-1:0]              wr_idx;
	logic [SIZE_BITS-1:0]          wr_data;
	logic                          out_load;
	logic                          nx_granted;
	logic [fpba_pkg::BLK_W-1:0]    nx_block;
	logic [fpba_pkg::AMT_W-1:0]    nx_space;
	logic [31:0]                   wr_data_ext;
	logic [31:0]                   fin_pick_ext;

	fpba_pkg::tok_flags_t          tok_chain  [0:NUM_BLOCKS];
	logic [IDX_W-1:0]              pick_chain [0:NUM_BLOCKS];
	logic [SIZE_BITS-1:0]          best_chain [0:NUM_BLOCKS];

	assign out_free   = !out_valid_q || m_tready;
	assign s_tready   = (state_q == fpba_pkg::ST_IDLE) && out_free;
	assign s_accept   = s_tvalid && s_tready;
	assign cfg_ready  = 1'b1;

	assign ld_idx     = s_tdata[fpba_pkg::BLK_W-1:0];
	assign ld_amt     = SIZE_BITS'(s_tdata[fpba_pkg::FIELDS_W-1:fpba_pkg::BLK_W]);
	assign ld_amt_ext = 32'(ld_amt);
	assign ld_idx_ext = 32'(ld_idx);
	assign ld_ok      = int'(ld_idx) < NUM_BLOCKS;
	assign amt_cur    = (state_q == fpba_pkg::ST_IDLE) ? ld_amt : amt_q;

	assign tok_chain[0].valid = s_accept && (s_tuser == fpba_pkg::OP_ALLOC);
	assign tok_chain[0].found = 1'b0;
	assign pick_chain[0]      = '0;
	assign best_chain[0]      = '0;

	for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
		fpba_cell #(
			.SIZE_BITS (SIZE_BITS),
			.IDX_W     (IDX_W),
			.CELL_IDX  (g)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.policy        (policy_q),
			.active_blocks (active_q),
			.amount        (amt_cur),
			.wr_en         (wr_en),
			.wr_idx        (wr_idx),
			.wr_data       (wr_data),
			.tok_in        (tok_chain[g]),
			.pick_in       (pick_chain[g]),
			.best_in       (best_chain[g]),
			.tok_out       (tok_chain[g+1]),
			.pick_out      (pick_chain[g+1]),
			.best_out      (best_chain[g+1])
		);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			fpba_pkg::ST_IDLE: begin
				if (s_accept && (s_tuser == fpba_pkg::OP_ALLOC)) begin
					state_nx = fpba_pkg::ST_SCAN;
				end
			end
			fpba_pkg::ST_SCAN: begin
				if (tok_chain[NUM_BLOCKS].valid) begin
					state_nx = fpba_pkg::ST_FIN;
				end
			end
			fpba_pkg::ST_FIN: begin
				if (out_free) begin
					state_nx = fpba_pkg::ST_IDLE;
				end
			end
			default: state_nx = fpba_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		wr_en        = 1'b0;
		wr_idx       = fin_pick_q;
		wr_data      = fin_best_q - amt_q;
		out_load     = 1'b0;
		nx_granted   = 1'b0;
		nx_block     = '0;
		nx_space     = '0;
		wr_data_ext  = 32'(fin_best_q - amt_q);
		fin_pick_ext = 32'(fin_pick_q);
		case (state_q)
			fpba_pkg::ST_IDLE: begin
				if (s_accept && (s_tuser == fpba_pkg::OP_LOAD)) begin
					out_load = 1'b1;
					if (ld_ok) begin
						wr_en      = 1'b1;
						wr_idx     = ld_idx_ext[IDX_W-1:0];
						wr_data    = ld_amt;
						nx_granted = 1'b1;
						nx_block   = ld_idx;
						nx_space   = ld_amt_ext[fpba_pkg::AMT_W-1:0];
					end
				end
			end
			fpba_pkg::ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					if (fin_found_q) begin
						wr_en      = 1'b1;
						nx_granted = 1'b1;
						nx_block   = fin_pick_ext[fpba_pkg::BLK_W-1:0];
						nx_space   = wr_data_ext[fpba_pkg::AMT_W-1:0];
					end
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpba_pkg::ST_IDLE;
			policy_q    <= fpba_pkg::POL_FIRST;
			active_q    <= fpba_pkg::ACTIVE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == fpba_pkg::REG_FIT_POLICY) begin
					policy_q <= cfg_data[1:0];
				end else if (cfg_index == fpba_pkg::REG_ACTIVE_BLOCKS) begin
					active_q <= cfg_data;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			amt_q <= ld_amt;
		end
		if ((state_q == fpba_pkg::ST_SCAN) && tok_chain[NUM_BLOCKS].valid) begin
			fin_found_q <= tok_chain[NUM_BLOCKS].found;
			fin_pick_q  <= pick_chain[NUM_BLOCKS];
			fin_best_q  <= best_chain[NUM_BLOCKS];
		end
		if (out_load) begin
			out_granted_q <= nx_granted;
			out_block_q   <= nx_block;
			out_space_q   <= nx_space;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_granted_q;
	assign m_tdata  = {{fpba_pkg::PAD_W{1'b0}}, out_space_q, out_block_q};

endmodule
`default_nettype wire

>>> sv/fpba_cell.sv
// One allocator cell: holds one block's free space and refines the passing search word.
`timescale 1ns / 1ps
`default_nettype none
module fpba_cell #(
	parameter int SIZE_BITS = 16,
	parameter int IDX_W     = 3,
	parameter int CELL_IDX  = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [1:0]                    policy,
	input  wire logic [fpba_pkg::ACTIVE_W-1:0] active_blocks,
	input  wire logic [SIZE_BITS-1:0]          amount,
	input  wire logic                          wr_en,
	input  wire logic [IDX_W-1:0]              wr_idx,
	input  wire logic [SIZE_BITS-1:0]          wr_data,
	input  wire fpba_pkg::tok_flags_t          tok_in,
	input  wire logic [IDX_W-1:0]              pick_in,
	input  wire logic [SIZE_BITS-1:0]          best_in,
	output fpba_pkg::tok_flags_t               tok_out,
	output logic [IDX_W-1:0]                   pick_out,
	output logic [SIZE_BITS-1:0]               best_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [SIZE_BITS-1:0] space_q;
	fpba_pkg::tok_flags_t tok_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;
	logic                 fits;
	logic                 take;

	always_comb begin
		fits = tok_in.valid && (int'(active_blocks) > CELL_IDX) && (space_q >= amount);
		take = 1'b0;
		if (fits) begin
			if (!tok_in.found) begin
				take = 1'b1;
			end else if (policy == fpba_pkg::POL_BEST) begin
				take = space_q < best_in;
			end else if (policy == fpba_pkg::POL_WORST) begin
				take = space_q > best_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_q <= '0;
			tok_q   <= '0;
		end else begin
			if (wr_en && (wr_idx == MY_IDX)) begin
				space_q <= wr_data;
			end
			tok_q.valid <= tok_in.valid;
			tok_q.found <= tok_in.found || take;
		end
	end

	always_ff @(posedge clk) begin
		pick_q <= take ? MY_IDX : pick_in;
		best_q <= take ? space_q : best_in;
	end

	assign tok_out  = tok_q;
	assign pick_out = pick_q;
	assign best_out = best_q;

endmodule
`default_nettype wire

>>> sv/fpba_checker.sv
// Port-level checker for the fit-policy block allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fpba_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            s_tuser,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [fpba_pkg::DATA_W-1:0]     m_tdata,
	input wire logic                            m_tuser
);

	// A result word that waits for the receiver stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// A refused operation reports zero block and zero space.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("refused result carries nonzero data");

	// An allocate word starts a scan, so no word is taken in the next cycle.
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == fpba_pkg::OP_ALLOC) |=> !s_tready)
		else $error("input taken during an allocation scan");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
